// ----- hw/rtl/kvprt_pkg.sv -----
// shared types and constants of the kv page range table
package kvprt_pkg;

  // table sizes
  localparam int unsigned MAX_PAGES   = 256;
  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned PAGE_AW     = $clog2(MAX_PAGES);
  localparam int unsigned ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned ENTRY_CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LIMIT_W     = $clog2(MAX_PAGES + 1);

  // sign bit of a 64-bit position, flipped to get an ordered key
  localparam logic [63:0] SIGN_BIAS = 64'h8000_0000_0000_0000;

  // action codes
  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_CLEAR    = 3'd2,
    ACT_VALIDATE = 3'd3,
    ACT_RESOLVE  = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_STALE    = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // configuration register indexes
  localparam logic CFG_PAGES_IN_USE = 1'b0;
  localparam logic CFG_TOKEN_LIMIT  = 1'b1;

  // page descriptor
  typedef struct packed {
    logic [31:0] gen;
    logic        live;
    logic [31:0] used;
  } page_t;

  // range entry
  typedef struct packed {
    logic [15:0] page;
    logic [31:0] gen;
    logic [63:0] base;
    logic [31:0] len;
  } entry_t;

endpackage

// ----- hw/rtl/kvprt_if.sv -----
// item channels and configuration channel of the kv page range table

// request item channel
interface kvprt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [15:0]        page_id;
  logic [31:0]        generation;
  logic signed [63:0] position;
  logic [31:0]        length;
  logic               page_live;
  logic [31:0]        page_used;

  modport source (output valid, action, page_id, generation, position, length,
                  page_live, page_used, input ready);
  modport sink   (input valid, action, page_id, generation, position, length,
                  page_live, page_used, output ready);
endinterface

// result item channel
interface kvprt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] found_page;
  logic [31:0] found_generation;
  logic [31:0] offset;

  modport source (output valid, status, found_page, found_generation, offset,
                  input ready);
  modport sink   (input valid, status, found_page, found_generation, offset,
                  output ready);
endinterface

// configuration write channel
interface kvprt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/kvprt_page_table.sv -----
// page descriptor memory with per-entry valid bits cleared at reset
module kvprt_page_table
  import kvprt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [PAGE_AW-1:0] wr_addr_i,
  input  page_t              wr_data_i,
  input  logic [PAGE_AW-1:0] rd_addr_i,
  output page_t              rd_data_o
);

  page_t                mem_q [MAX_PAGES];
  logic [MAX_PAGES-1:0] vld_q;
  page_t                rd_q;
  logic                 rd_vld_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) vld_q[wr_addr_i] <= 1'b1;
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    rd_q <= mem_q[rd_addr_i];
  end

  // never-loaded page reads as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- hw/rtl/kv_page_range_table.sv -----
// kv page range table top level: page table, entry list, validate and resolve
//
//  channel   | dir | handshake    | moves
//  ----------+-----+--------------+-----------------------------------------
//  in_item   | in  | valid/ready  | action, page, generation, position, ...
//  out_item  | out | valid/ready  | status, found page, generation, offset
//  cfg       | in  | valid/ready  | register index and write data
//
// load, append and clear give no result item and leave the block idle.
// validate: each entry needs an entry read and a page read, and each earlier
// entry one more entry read for the overlap compare, all through one entry
// memory port. resolve reads the entries in turn through the same port and
// then checks the page of the first entry that covers the position.
// reset clears page valid bits and the entry count at once, no sweep.
// a new item is taken while a result waits at the output register.
module kv_page_range_table
  import kvprt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  kvprt_in_if.sink   in_item,
  kvprt_out_if.source out_item,
  kvprt_cfg_if.sink  cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_VI, S_VI2, S_VP, S_VJ, S_VJ2, S_RI, S_R2, S_RP, S_DONE
  } state_e;

  state_e              state_q;
  logic [8:0]          pages_in_use_q;
  logic [15:0]         tok_limit_q;
  logic [ENTRY_CW-1:0] total_q;
  logic [ENTRY_AW-1:0] i_q, j_q;
  entry_t              cur_q;
  logic [64:0]         cur_key_q, cur_end_q;
  logic                cur_ovf_q;
  logic [63:0]         pos_q;
  status_e             res_status_q;
  logic [15:0]         res_page_q;
  logic [31:0]         res_gen_q, res_off_q;
  logic                out_valid_q;
  logic [2:0]          out_status_q;
  logic [15:0]         out_page_q;
  logic [31:0]         out_gen_q, out_off_q;

  entry_t              entry_mem_q [MAX_ENTRIES];
  entry_t              ent_q;
  logic [ENTRY_AW-1:0] ent_raddr;
  page_t               page_rd;
  page_t               page_wdata;
  logic                in_acc, page_wr, ent_wr;
  logic [LIMIT_W-1:0]  lim;
  logic                page_oor;
  logic [64:0]         ent_key, ent_end, pos_key;
  logic [63:0]         ent_sum;
  logic                last_i, last_j;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_in_use_q <= '0;
      tok_limit_q    <= 16'd16;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PAGES_IN_USE: pages_in_use_q <= cfg.data[8:0];
        CFG_TOKEN_LIMIT:  tok_limit_q    <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake and write strobes
  assign in_item.ready = (state_q == S_IDLE);
  assign in_acc  = in_item.valid && (state_q == S_IDLE);
  assign page_wr = in_acc && (in_item.action == ACT_LOAD) &&
                   ({1'b0, in_item.page_id} < 17'(MAX_PAGES));
  assign ent_wr  = in_acc && (in_item.action == ACT_APPEND) &&
                   (total_q < ENTRY_CW'(MAX_ENTRIES));

  // page descriptor table, read at the page of the entry just read
  assign page_wdata = '{gen: in_item.generation, live: in_item.page_live,
                        used: in_item.page_used};
  kvprt_page_table u_page_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (page_wr),
    .wr_addr_i (in_item.page_id[PAGE_AW-1:0]),
    .wr_data_i (page_wdata),
    .rd_addr_i (ent_q.page[PAGE_AW-1:0]),
    .rd_data_o (page_rd)
  );

  // entry memory
  assign ent_raddr = (state_q == S_VJ) ? j_q : i_q;
  always_ff @(posedge clk_i) begin
    if (ent_wr) begin
      entry_mem_q[total_q[ENTRY_AW-1:0]] <= '{page: in_item.page_id,
                                              gen: in_item.generation,
                                              base: in_item.position,
                                              len: in_item.length};
    end
    ent_q <= entry_mem_q[ent_raddr];
  end

  // page limit and entry keys
  assign lim      = (pages_in_use_q > 9'(MAX_PAGES)) ? LIMIT_W'(MAX_PAGES)
                                                     : LIMIT_W'(pages_in_use_q);
  assign page_oor = {1'b0, ent_q.page} >= 17'(lim);
  assign ent_key  = {1'b0, ent_q.base ^ SIGN_BIAS};
  assign ent_end  = ent_key + {33'd0, ent_q.len};
  assign ent_sum  = ent_q.base + {32'd0, ent_q.len};
  assign pos_key  = {1'b0, pos_q ^ SIGN_BIAS};
  assign last_i   = ({1'b0, i_q} + ENTRY_CW'(1)) == total_q;
  assign last_j   = (j_q + ENTRY_AW'(1)) == i_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      if (out_valid_q && out_item.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_status_q <= ((in_item.action == ACT_RESOLVE) &&
                             (in_item.position[63] || total_q == '0)) ? ST_NOTFOUND
                                                                        : ST_OK;
            res_page_q   <= '0;
            res_gen_q    <= '0;
            res_off_q    <= '0;
            i_q          <= '0;
            pos_q        <= in_item.position;
            case (in_item.action)
              ACT_APPEND: if (ent_wr) total_q <= total_q + ENTRY_CW'(1);
              ACT_CLEAR: total_q <= '0;
              ACT_VALIDATE: state_q <= (total_q == '0) ? S_DONE : S_VI;
              ACT_RESOLVE: begin
                if (in_item.position[63] || total_q == '0) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_RI;
                end
              end
              default: ;
            endcase
          end
        end
        // validate: entry i read issued
        S_VI: state_q <= S_VI2;
        S_VI2: begin
          cur_q     <= ent_q;
          cur_key_q <= ent_key;
          cur_end_q <= ent_end;
          cur_ovf_q <= ent_sum[63];
          if (page_oor || ent_q.base[63] || ent_q.len == '0 ||
              ent_q.len > {16'd0, tok_limit_q}) begin
            res_status_q <= ST_RANGE;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_VP;
          end
        end
        S_VP: begin
          j_q <= '0;
          if (page_rd.gen != cur_q.gen) begin
            res_status_q <= ST_STALE;
            state_q      <= S_DONE;
          end else if (!page_rd.live || page_rd.used < cur_q.len || cur_ovf_q) begin
            res_status_q <= ST_RANGE;
            state_q      <= S_DONE;
          end else if (i_q != '0) begin
            state_q <= S_VJ;
          end else if (last_i) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q + ENTRY_AW'(1);
            state_q <= S_VI;
          end
        end
        // overlap compare against earlier entry j
        S_VJ: state_q <= S_VJ2;
        S_VJ2: begin
          if ((cur_key_q < ent_end) && (ent_key < cur_end_q)) begin
            res_status_q <= ST_OVERLAP;
            state_q      <= S_DONE;
          end else if (!last_j) begin
            j_q     <= j_q + ENTRY_AW'(1);
            state_q <= S_VJ;
          end else if (last_i) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q + ENTRY_AW'(1);
            state_q <= S_VI;
          end
        end
        // resolve scan
        S_RI: state_q <= S_R2;
        S_R2: begin
          cur_q <= ent_q;
          if (!(pos_key < ent_key) && (pos_key < ent_end)) begin
            if (page_oor) begin
              res_status_q <= ST_RANGE;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_RP;
            end
          end else if (last_i) begin
            res_status_q <= ST_NOTFOUND;
            state_q      <= S_DONE;
          end else begin
            i_q     <= i_q + ENTRY_AW'(1);
            state_q <= S_RI;
          end
        end
        S_RP: begin
          if (page_rd.gen != cur_q.gen) begin
            res_status_q <= ST_STALE;
          end else begin
            res_page_q <= cur_q.page;
            res_gen_q  <= cur_q.gen;
            res_off_q  <= 32'(pos_q - cur_q.base);
          end
          state_q <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_q || out_item.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_page_q   <= res_page_q;
            out_gen_q    <= res_gen_q;
            out_off_q    <= res_off_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result item outputs
  assign out_item.valid            = out_valid_q;
  assign out_item.status           = out_status_q;
  assign out_item.found_page       = out_page_q;
  assign out_item.found_generation = out_gen_q;
  assign out_item.offset           = out_off_q;

endmodule

// ----- bench/kvprt_checker.sv -----
// checker: watches the channels, predicts results of the page range table, compares
`timescale 1ns / 100ps

module kvprt_checker
  import kvprt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  kvprt_in_if   in_item,
  kvprt_out_if  out_item,
  kvprt_cfg_if  cfg,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    status_e     status;
    logic [15:0] page;
    logic [31:0] gen;
    logic [31:0] offset;
  } lookup_t;

  // predicted copy of the block state
  logic [8:0]  pages_in_use;
  logic [15:0] tok_max;
  logic [31:0] pg_gen  [MAX_PAGES];
  logic        pg_live [MAX_PAGES];
  logic [31:0] pg_used [MAX_PAGES];
  logic [15:0] ent_page [MAX_ENTRIES];
  logic [31:0] ent_gen  [MAX_ENTRIES];
  logic [63:0] ent_base [MAX_ENTRIES];
  logic [31:0] ent_len  [MAX_ENTRIES];
  int unsigned ent_total;

  lookup_t awaited_q[$];
  int      mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = awaited_q.size();

  function automatic int unsigned page_bound();
    return (pages_in_use < MAX_PAGES) ? int'(pages_in_use) : MAX_PAGES;
  endfunction

  // order-preserving 65-bit key of a signed position
  function automatic logic [64:0] key_of(logic [63:0] v);
    return {1'b0, v ^ SIGN_BIAS};
  endfunction

  function automatic logic [64:0] end_of(logic [63:0] v, logic [31:0] len);
    return key_of(v) + {33'b0, len};
  endfunction

  // first fault over the entry list
  function automatic status_e check_entries();
    int unsigned lim;
    logic [15:0] pg;
    logic [64:0] b, e, pb, pe;
    lim = page_bound();
    for (int unsigned i = 0; i < ent_total; i++) begin
      pg = ent_page[i];
      if (pg >= lim || ent_base[i][63] || ent_len[i] == 0 ||
          ent_len[i] > {16'b0, tok_max})
        return ST_RANGE;
      if (pg_gen[pg] != ent_gen[i]) return ST_STALE;
      if (!pg_live[pg] || pg_used[pg] < ent_len[i]) return ST_RANGE;
      if (ent_base[i] > 64'h7FFF_FFFF_FFFF_FFFF - {32'b0, ent_len[i]}) return ST_RANGE;
      b = key_of(ent_base[i]);
      e = end_of(ent_base[i], ent_len[i]);
      for (int unsigned j = 0; j < i; j++) begin
        pb = key_of(ent_base[j]);
        pe = end_of(ent_base[j], ent_len[j]);
        if (b < pe && pb < e) return ST_OVERLAP;
      end
    end
    return ST_OK;
  endfunction

  // first entry covering a logical position
  function automatic lookup_t lookup_position(logic [63:0] pos);
    lookup_t r;
    logic [64:0] p;
    logic [15:0] pg;
    r = '{ST_NOTFOUND, 16'd0, 32'd0, 32'd0};
    if (pos[63]) return r;
    p = key_of(pos);
    for (int unsigned i = 0; i < ent_total; i++) begin
      if (p >= key_of(ent_base[i]) && p < end_of(ent_base[i], ent_len[i])) begin
        pg = ent_page[i];
        if (pg >= page_bound()) begin
          r.status = ST_RANGE;
        end else if (pg_gen[pg] != ent_gen[i]) begin
          r.status = ST_STALE;
        end else begin
          r.status = ST_OK;
          r.page   = pg;
          r.gen    = ent_gen[i];
          r.offset = 32'(pos - ent_base[i]);
        end
        return r;
      end
    end
    return r;
  endfunction

  // state update and result prediction on accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t exp_r;
    lookup_t got;
    if (!rst_ni) begin
      pages_in_use <= '0;
      tok_max      <= 16'd16;
      ent_total    <= 0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        pg_gen[i]  <= '0;
        pg_live[i] <= 1'b0;
        pg_used[i] <= '0;
      end
      awaited_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_PAGES_IN_USE) pages_in_use <= cfg.data[8:0];
        else tok_max <= cfg.data;
      end
      if (in_item.valid && in_item.ready) begin
        case (in_item.action)
          ACT_LOAD: begin
            if (in_item.page_id < MAX_PAGES) begin
              pg_gen[in_item.page_id]  <= in_item.generation;
              pg_live[in_item.page_id] <= in_item.page_live;
              pg_used[in_item.page_id] <= in_item.page_used;
            end
          end
          ACT_APPEND: begin
            if (ent_total < MAX_ENTRIES) begin
              ent_page[ent_total] <= in_item.page_id;
              ent_gen[ent_total]  <= in_item.generation;
              ent_base[ent_total] <= in_item.position;
              ent_len[ent_total]  <= in_item.length;
              ent_total <= ent_total + 1;
            end
          end
          ACT_CLEAR: ent_total <= 0;
          ACT_VALIDATE: awaited_q.push_back('{check_entries(), 16'd0, 32'd0, 32'd0});
          ACT_RESOLVE: awaited_q.push_back(lookup_position(in_item.position));
          default: ;
        endcase
      end
      // compare result items with the oldest prediction
      if (out_item.valid && out_item.ready) begin
        got = '{status_e'(out_item.status), out_item.found_page,
                out_item.found_generation, out_item.offset};
        if (awaited_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: status %0d page %0d gen %h offset %0d",
                     got.status, got.page, got.gen, got.offset);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = awaited_q.pop_front();
          if (got != exp_r) begin
            if (mismatches < 10)
              $display("mismatch: expected status %0d page %0d gen %h offset %0d, got %0d %0d %h %0d",
                       exp_r.status, exp_r.page, exp_r.gen, exp_r.offset,
                       got.status, got.page, got.gen, got.offset);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
// testbench top: clock, reset, stimulus and verdict for the page range table
`timescale 1ns / 100ps

module testbench;
  import kvprt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   items = 0;
  logic steady = 1'b0;

  kvprt_in_if  in_item ();
  kvprt_out_if out_item ();
  kvprt_cfg_if cfg ();

  kv_page_range_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_item(in_item), .out_item(out_item), .cfg(cfg)
  );

  kvprt_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_item(in_item), .out_item(out_item), .cfg(cfg),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_item.ready <= steady || ($urandom_range(99) >= 13);
  end

  // page limit and length limit as the stimulus sees them
  int unsigned lim_pages = 0;
  int unsigned tok_limit = 16;

  task automatic write_reg(logic idx, logic [15:0] val);
    // stop sending, wait for idle, then wait longer for late append or load work
    in_item.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    forever begin
      @(negedge clk_i);
      if (cfg.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg.valid <= 1'b0;
    if (idx == CFG_PAGES_IN_USE) lim_pages = (val[8:0] < MAX_PAGES) ? val[8:0] : MAX_PAGES;
    else tok_limit = val;
  endtask

  task automatic send(action_e act, logic [15:0] pid, logic [31:0] gen, logic [63:0] pos,
                      logic [31:0] len, logic live, logic [31:0] used);
    int gap;
    if (!steady && $urandom_range(99) < 13) begin
      gap = $urandom_range(4, 1);
      in_item.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item.valid      <= 1'b1;
    in_item.action     <= act;
    in_item.page_id    <= pid;
    in_item.generation <= gen;
    in_item.position   <= pos;
    in_item.length     <= len;
    in_item.page_live  <= live;
    in_item.page_used  <= used;
    forever begin
      @(negedge clk_i);
      if (in_item.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    items++;
  endtask

  task automatic send_noise();
    send(action_e'($urandom_range(7)), 16'($urandom), $urandom, {$urandom, $urandom},
         $urandom, 1'($urandom), $urandom);
  endtask

  // mostly well-formed table with some injected faults: load pages, append ranges, validate, resolve around them
  task automatic run_sequence();
    logic [15:0] pids [8];
    logic [31:0] gens [8];
    logic [63:0] cursor, start, pos;
    logic [31:0] len;
    int npg, nent, k, nres;
    npg = $urandom_range(6, 1);
    send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < npg; i++) begin
      pids[i] = (lim_pages > 0) ? 16'($urandom_range(lim_pages - 1)) : 16'($urandom_range(255));
      if ($urandom_range(9) == 0) pids[i] = 16'($urandom_range(300));
      gens[i] = $urandom;
      send(ACT_LOAD, pids[i], gens[i], 0, 0, $urandom_range(9) != 0,
           ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40)));
    end
    nent = ($urandom_range(19) == 0) ? $urandom_range(66, 60) : $urandom_range(10);
    case ($urandom_range(3))
      0: start = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(200));
      1: start = {1'b0, 31'($urandom), $urandom};
      default: start = 64'($urandom_range(100));
    endcase
    cursor = start;
    for (int i = 0; i < nent; i++) begin
      k = $urandom_range(npg - 1);
      len = (tok_limit > 0) ? 32'($urandom_range(tok_limit > 40 ? 40 : tok_limit, 1)) : 32'd1;
      if ($urandom_range(19) == 0) len = ($urandom_range(1)) ? 32'd0 : $urandom;
      pos = cursor;
      if ($urandom_range(14) == 0) pos = cursor - 64'($urandom_range(5));
      send(ACT_APPEND, pids[k], ($urandom_range(14) == 0) ? gens[k] ^ 32'd1 : gens[k],
           pos, len, 0, 0);
      cursor = pos + 64'(len) + 64'($urandom_range(3));
    end
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    nres = $urandom_range(5, 1);
    for (int i = 0; i < nres; i++) begin
      pos = start + 64'($urandom_range(int'(cursor - start) + 4 > 0 ? 600 : 600));
      if ($urandom_range(9) == 0) pos = {$urandom, $urandom};
      send(ACT_RESOLVE, 0, 0, pos, 0, 0, 0);
    end
  endtask

  initial begin
    in_item.valid = 1'b0;
    in_item.action = ACT_LOAD;
    in_item.page_id = '0;
    in_item.generation = '0;
    in_item.position = '0;
    in_item.length = '0;
    in_item.page_live = 1'b0;
    in_item.page_used = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PAGES_IN_USE;
    cfg.data = '0;
    out_item.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, unknown actions, no pages in use
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    send(ACT_RESOLVE, 0, 0, 64'd5, 0, 0, 0);
    send(action_e'(3'd5), 0, 0, 0, 0, 0, 0);
    send(action_e'(3'd7), 16'hFFFF, '1, '1, '1, 1, '1);
    send(ACT_APPEND, 0, 0, 0, 1, 0, 0);
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    send(ACT_RESOLVE, 0, 0, 0, 0, 0, 0);
    write_reg(CFG_PAGES_IN_USE, 16'd256);
    write_reg(CFG_TOKEN_LIMIT, 16'd16);
    // page extremes, ignored load above the table
    send(ACT_LOAD, 16'd0, 32'd0, 0, 0, 1, 32'hFFFF_FFFF);
    send(ACT_LOAD, 16'd255, 32'hFFFF_FFFF, 0, 0, 1, 32'd16);
    send(ACT_LOAD, 16'd256, 32'd7, 0, 0, 1, 32'd16);
    send(ACT_LOAD, 16'hFFFF, 32'd7, 0, 0, 0, 32'd0);
    send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    send(ACT_APPEND, 16'd0, 32'd0, 64'd0, 32'd16, 0, 0);
    send(ACT_APPEND, 16'd255, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFF0, 32'd15, 0, 0);
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    send(ACT_RESOLVE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFE, 0, 0, 0);
    send(ACT_RESOLVE, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0);
    send(ACT_RESOLVE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    // overlap, end overflow, stale
    send(ACT_APPEND, 16'd0, 32'd0, 64'd8, 32'd4, 0, 0);
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    send(ACT_APPEND, 16'd255, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'd16, 0, 0);
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);
    send(ACT_APPEND, 16'd255, 32'd3, 64'd100, 32'hFFFF_FFFF, 0, 0);
    send(ACT_RESOLVE, 0, 0, 64'd200, 0, 0, 0);
    send(ACT_VALIDATE, 0, 0, 0, 0, 0, 0);

    // random phases over several register settings
    for (int ph = 0; items < 750; ph++) begin
      case (ph % 7)
        0: begin write_reg(CFG_PAGES_IN_USE, 16'd256); write_reg(CFG_TOKEN_LIMIT, 16'd16); end
        1: begin write_reg(CFG_PAGES_IN_USE, 16'h1FF); write_reg(CFG_TOKEN_LIMIT, 16'hFFFF); end
        2: write_reg(CFG_TOKEN_LIMIT, 16'd0);
        3: begin write_reg(CFG_PAGES_IN_USE, 16'd1); write_reg(CFG_TOKEN_LIMIT, 16'd1); end
        4: begin
          write_reg(CFG_PAGES_IN_USE, 16'($urandom));
          write_reg(CFG_TOKEN_LIMIT, 16'($urandom_range(64, 1)));
        end
        5: write_reg(CFG_PAGES_IN_USE, 16'd0);
        default: begin write_reg(CFG_PAGES_IN_USE, 16'd8); write_reg(CFG_TOKEN_LIMIT, 16'd32); end
      endcase
      steady <= (ph % 5 == 3);
      for (int s = 0; s < 6 && items < 750; s++) begin
        if ($urandom_range(4) == 0) repeat ($urandom_range(6, 1)) send_noise();
        else run_sequence();
      end
    end
    in_item.valid <= 1'b0;
    steady <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/kvprt_pkg.sv
hw/rtl/kvprt_if.sv
hw/rtl/kvprt_page_table.sv
hw/rtl/kv_page_range_table.sv
bench/kvprt_checker.sv
bench/testbench.sv
